FILE: sv/wdtc_pkg.sv
// shared types and constants for the wheel drive and tick counter
`default_nettype none

package wdtc_pkg;

    // command codes on the input tuser
    localparam logic [1:0] CMD_SET_SPEED = 2'd0;
    localparam logic [1:0] CMD_EDGE      = 2'd1;
    localparam logic [1:0] CMD_CLEAR     = 2'd2;

    // driver kinds
    localparam logic [1:0] KIND_ESC     = 2'd0;
    localparam logic [1:0] KIND_DRV8833 = 2'd1;
    localparam logic [1:0] KIND_TB6612  = 2'd2;

    // line modes
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DRIVER_KIND  = 2'd0;
    localparam logic [1:0] REG_REVERSE      = 2'd1;
    localparam logic [1:0] REG_HAS_DIR_LINE = 2'd2;

    localparam int ADDR_W    = 4;
    localparam int SPEED_W   = 16;
    localparam int CLAMP_W   = 9;
    localparam int PULSE_W   = 11;
    localparam int DUTY_W    = 8;
    localparam int TICK_W    = 32;
    localparam int MULT_W    = 18;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd255;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd255;

    localparam logic [PULSE_W-1:0] PULSE_MIN   = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX   = 11'd2000;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 11'd1500;

    // (v * 1000) / 510 == (v * 100 * ceil(2^22 / 51)) >> 22 for v in 0..510
    localparam logic [32:0] ESC_MUL   = 33'd8224200;
    localparam int          ESC_SHIFT = 22;

    typedef struct packed {
        logic [1:0] driver_kind;
        logic       reverse;
        logic       has_direction_line;
    } cfg_t;

    // count direction update produced by a speed change
    typedef struct packed {
        logic set;
        logic down;
    } dir_upd_t;

endpackage

`default_nettype wire

FILE: sv/wdtc_cfg.sv
// apb configuration registers
`default_nettype none

module wdtc_cfg
    import wdtc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DRIVER_KIND:  cfg_reg.driver_kind        <= pwdata[1:0];
                REG_REVERSE:      cfg_reg.reverse            <= pwdata[0];
                REG_HAS_DIR_LINE: cfg_reg.has_direction_line <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DRIVER_KIND:  prdata = {30'd0, cfg_reg.driver_kind};
            REG_REVERSE:      prdata = {31'd0, cfg_reg.reverse};
            REG_HAS_DIR_LINE: prdata = {31'd0, cfg_reg.has_direction_line};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/wdtc_drive.sv
// speed command mapper holding the drive outputs
`default_nettype none

module wdtc_drive
    import wdtc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cfg_t                      cfg,
    input  wire logic                      apply,
    input  wire logic signed [SPEED_W-1:0] speed,
    output dir_upd_t                       dir_upd,
    output logic        [PULSE_W-1:0]      pulse_us,
    output logic        [1:0]              a_mode,
    output logic        [1:0]              b_mode,
    output logic        [1:0]              sl_mode,
    output logic        [DUTY_W-1:0]       duty
);

    logic signed [CLAMP_W-1:0] last_speed_reg;
    logic        [PULSE_W-1:0] pulse_reg, pulse_next;
    logic        [1:0]         a_mode_reg, a_mode_next;
    logic        [1:0]         b_mode_reg, b_mode_next;
    logic        [1:0]         sl_mode_reg, sl_mode_next;
    logic        [DUTY_W-1:0]  duty_reg, duty_next;

    logic                      changed;
    logic signed [CLAMP_W-1:0] s;
    logic signed [CLAMP_W-1:0] d;
    logic        [DUTY_W-1:0]  mag;
    logic        [9:0]         esc_v;
    logic        [32:0]        esc_prod;
    logic        [9:0]         esc_step;

    // raw request is compared against the clamped stored speed
    assign changed = apply &&
                     (speed != {{(SPEED_W-CLAMP_W){last_speed_reg[CLAMP_W-1]}}, last_speed_reg});

    always_comb begin
        if (speed > SPEED_MAX) begin
            s = SPEED_MAX[CLAMP_W-1:0];
        end else if (speed < SPEED_MIN) begin
            s = SPEED_MIN[CLAMP_W-1:0];
        end else begin
            s = speed[CLAMP_W-1:0];
        end
    end

    assign d   = cfg.reverse ? -s : s;
    assign mag = d[CLAMP_W-1] ? DUTY_W'(-d) : DUTY_W'(d);

    // esc map uses the un-reversed speed
    assign esc_v    = 10'($signed({s[CLAMP_W-1], s}) + 10'sd255);
    assign esc_prod = 33'(esc_v) * ESC_MUL;
    assign esc_step = esc_prod[ESC_SHIFT+9:ESC_SHIFT];

    assign dir_upd.set  = changed && !cfg.has_direction_line && (s != '0);
    assign dir_upd.down = s[CLAMP_W-1];

    always_comb begin
        pulse_next   = pulse_reg;
        a_mode_next  = a_mode_reg;
        b_mode_next  = b_mode_reg;
        sl_mode_next = sl_mode_reg;
        duty_next    = duty_reg;
        unique case (cfg.driver_kind)
            KIND_ESC: begin
                pulse_next = cfg.reverse ? PULSE_MAX - PULSE_W'(esc_step)
                                         : PULSE_MIN + PULSE_W'(esc_step);
            end
            KIND_DRV8833: begin
                if (d == '0) begin
                    a_mode_next = MODE_HIGH;
                    b_mode_next = MODE_HIGH;
                end else begin
                    a_mode_next = d[CLAMP_W-1] ? MODE_PWM : MODE_HIGH;
                    b_mode_next = d[CLAMP_W-1] ? MODE_HIGH : MODE_PWM;
                    duty_next   = 8'd255 - mag;
                end
            end
            KIND_TB6612: begin
                if (d == '0) begin
                    a_mode_next  = MODE_HIGH;
                    b_mode_next  = MODE_HIGH;
                    sl_mode_next = MODE_HIGH;
                end else begin
                    a_mode_next  = d[CLAMP_W-1] ? MODE_LOW : MODE_HIGH;
                    b_mode_next  = d[CLAMP_W-1] ? MODE_HIGH : MODE_LOW;
                    sl_mode_next = MODE_PWM;
                    duty_next    = mag;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_speed_reg <= '0;
            pulse_reg      <= PULSE_RESET;
            a_mode_reg     <= MODE_LOW;
            b_mode_reg     <= MODE_LOW;
            sl_mode_reg    <= MODE_LOW;
            duty_reg       <= '0;
        end else if (changed) begin
            last_speed_reg <= s;
            pulse_reg      <= pulse_next;
            a_mode_reg     <= a_mode_next;
            b_mode_reg     <= b_mode_next;
            sl_mode_reg    <= sl_mode_next;
            duty_reg       <= duty_next;
        end
    end

    assign pulse_us = pulse_reg;
    assign a_mode   = a_mode_reg;
    assign b_mode   = b_mode_reg;
    assign sl_mode  = sl_mode_reg;
    assign duty     = duty_reg;

endmodule

`default_nettype wire

FILE: sv/wdtc_ticks.sv
// encoder tick counter with low count and wrap multiple
`default_nettype none

module wdtc_ticks
    import wdtc_pkg::*;
#(
    parameter int COUNT_SPAN = 16384
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              has_direction_line,
    input  wire dir_upd_t          dir_upd,
    input  wire logic              edge_in,
    input  wire logic              clear,
    output logic      [TICK_W-1:0] tick_count
);

    localparam int LOW_W = $clog2(COUNT_SPAN + 1) + 1;
    localparam logic signed [LOW_W-1:0] SPAN_POS = LOW_W'(COUNT_SPAN);
    localparam logic signed [LOW_W-1:0] SPAN_NEG = -SPAN_POS;
    localparam logic [TICK_W-1:0] SPAN_T = TICK_W'(COUNT_SPAN);

    logic                    count_down_reg;
    logic signed [LOW_W-1:0] low_reg, low_next;
    logic        [MULT_W-1:0] mult_reg, mult_next;
    logic        [TICK_W-1:0] total_reg;
    logic signed [LOW_W-1:0] low_inc, low_dec;
    logic                    down;

    assign down    = !has_direction_line && count_down_reg;
    assign low_inc = low_reg + LOW_W'(1);
    assign low_dec = low_reg - LOW_W'(1);

    always_comb begin
        low_next  = low_reg;
        mult_next = mult_reg;
        if (clear) begin
            low_next  = '0;
            mult_next = '0;
        end else if (edge_in) begin
            if (down) begin
                if (low_dec <= SPAN_NEG) begin
                    low_next  = '0;
                    mult_next = mult_reg - MULT_W'(1);
                end else begin
                    low_next = low_dec;
                end
            end else begin
                if (low_inc >= SPAN_POS) begin
                    low_next  = '0;
                    mult_next = mult_reg + MULT_W'(1);
                end else begin
                    low_next = low_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_down_reg <= 1'b0;
            low_reg        <= '0;
            mult_reg       <= '0;
            total_reg      <= '0;
        end else begin
            if (dir_upd.set) begin
                count_down_reg <= dir_upd.down;
            end
            low_reg   <= low_next;
            mult_reg  <= mult_next;
            // total = multiple * span + low, modulo 2^32
            total_reg <= {{(TICK_W-MULT_W){mult_next[MULT_W-1]}}, mult_next} * SPAN_T
                         + {{(TICK_W-LOW_W){low_next[LOW_W-1]}}, low_next};
        end
    end

    assign tick_count = total_reg;

endmodule

`default_nettype wire

FILE: sv/wheel_drive_and_tick_counter.sv
// wheel drive command mapper and encoder tick counter, top level
//
// input stream (s_*): one beat per command; s_tuser carries the command
// (set speed, encoder edge, clear tick count), s_tdata the signed speed.
// result stream (m_*): exactly one beat per input beat, in order, showing the
// held drive outputs and the tick total after that command.
// apb port: driver kind, reverse and has-direction-line registers at byte
// addresses 0, 4 and 8; write only while no command is in flight.
// an accepted beat waits in the input register and is presented on m_* once
// it advances. throughput: one beat per cycle while m_tready is high; each
// command passes the input register and then updates the drive and counter
// state, which doubles as the result register.
// stall: while m_tready is low the result holds and one more beat can wait in
// the input register; s_tready drops only when both are full.
// reset (aresetn low, synchronous): both stages empty, pulse 1500 us, all
// lines low, duty and tick total zero, counting up, registers zero.
`default_nettype none

module wheel_drive_and_tick_counter
    import wdtc_pkg::*;
#(
    parameter int COUNT_SPAN = 16384
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] speed
    input  wire logic [1:0]        s_tuser,   // [1:0] cmd
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [10:0] esc_pulse_us, [12:11] line_a_mode, [14:13] line_b_mode,
    // [16:15] speed_line_mode, [24:17] duty, [56:25] tick_count, [63:57] zero
    output logic      [63:0]       m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t        cfg;
    dir_upd_t    dir_upd;
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] speed_reg;
    logic        out_valid_reg;
    logic        advance;

    logic [PULSE_W-1:0] pulse_us;
    logic [1:0]         a_mode, b_mode, sl_mode;
    logic [DUTY_W-1:0]  duty;
    logic [TICK_W-1:0]  tick_count;

    assign pready   = 1'b1;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg   <= s_tuser;
            speed_reg <= s_tdata;
        end
    end

    wdtc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    wdtc_drive u_drive (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .apply    (advance && (cmd_reg == CMD_SET_SPEED)),
        .speed    ($signed(speed_reg)),
        .dir_upd  (dir_upd),
        .pulse_us (pulse_us),
        .a_mode   (a_mode),
        .b_mode   (b_mode),
        .sl_mode  (sl_mode),
        .duty     (duty)
    );

    wdtc_ticks #(
        .COUNT_SPAN (COUNT_SPAN)
    ) u_ticks (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .has_direction_line (cfg.has_direction_line),
        .dir_upd            (dir_upd),
        .edge_in            (advance && (cmd_reg == CMD_EDGE)),
        .clear              (advance && (cmd_reg == CMD_CLEAR)),
        .tick_count         (tick_count)
    );

    // the held state only moves on advance, so it is the result register
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, tick_count, duty, sl_mode, b_mode, a_mode, pulse_us};

endmodule

`default_nettype wire

FILE: sv/wdtc_checker.sv
// port-level checks for the wheel drive and tick counter
`default_nettype none

module wdtc_checker
    import wdtc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an accepted command is always followed by a valid result beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result beat two cycles after accept");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] >= PULSE_MIN) && (m_tdata[10:0] <= PULSE_MAX))
        else $error("esc pulse out of range");

    a_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:11] == MODE_LOW || m_tdata[12:11] == MODE_HIGH ||
                      m_tdata[12:11] == MODE_PWM) &&
                     (m_tdata[14:13] == MODE_LOW || m_tdata[14:13] == MODE_HIGH ||
                      m_tdata[14:13] == MODE_PWM) &&
                     (m_tdata[16:15] == MODE_LOW || m_tdata[16:15] == MODE_HIGH ||
                      m_tdata[16:15] == MODE_PWM))
        else $error("line mode code out of range");

endmodule

bind wheel_drive_and_tick_counter wdtc_checker u_wdtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/wheel_drive_and_tick_counter_tb.sv
// self-checking bench for the wheel drive mapper and encoder tick counter
`default_nettype none

module wheel_drive_and_tick_counter_tb;
    import wdtc_pkg::*;

    // small span so the low counter wraps many times in a short run
    localparam int SPAN       = 7;
    localparam int CYCLE_CAP  = 500000;
    localparam int LONG_HOLD  = 400;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 250;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] tick;
        logic [7:0]  duty;
        logic [1:0]  speed_line;
        logic [1:0]  line_b;
        logic [1:0]  line_a;
        logic [10:0] pulse;
    } drive_outputs_t;

    class wheel_state_board;
        int span;
        logic [1:0] kind;
        bit reverse_on;
        bit dir_line;
        logic signed [8:0] last_speed;
        bit count_down;
        int low_count;
        logic [17:0] wrap_mult;
        logic [10:0] pulse;
        logic [1:0] a_mode;
        logic [1:0] b_mode;
        logic [1:0] sl_mode;
        logic [7:0] duty;
        drive_outputs_t held_outputs_q[$];
        int failures;

        function new(int count_span);
            span = count_span;
            kind = KIND_ESC;
            reverse_on = 0;
            dir_line = 0;
            last_speed = '0;
            count_down = 0;
            low_count = 0;
            wrap_mult = '0;
            pulse = PULSE_RESET;
            a_mode = MODE_LOW;
            b_mode = MODE_LOW;
            sl_mode = MODE_LOW;
            duty = '0;
            failures = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_DRIVER_KIND:  kind = value[1:0];
                REG_REVERSE:      reverse_on = value[0];
                REG_HAS_DIR_LINE: dir_line = value[0];
                default: ;
            endcase
        endfunction

        function void apply_speed(logic [15:0] speed);
            int req;
            int s;
            int d;
            int mag;
            int step;
            req = $signed(speed);
            if (req == last_speed)
                return;
            s = req > int'(SPEED_MAX) ? int'(SPEED_MAX) :
                (req < int'(SPEED_MIN) ? int'(SPEED_MIN) : req);
            if (!dir_line) begin
                if (s > 0)
                    count_down = 0;
                else if (s < 0)
                    count_down = 1;
            end
            d = reverse_on ? -s : s;
            mag = d < 0 ? -d : d;
            case (kind)
                KIND_ESC: begin
                    step = ((s + 255) * 1000) / 510;
                    pulse = reverse_on ? 11'(int'(PULSE_MAX) - step)
                                       : 11'(int'(PULSE_MIN) + step);
                end
                KIND_DRV8833: begin
                    if (d == 0) begin
                        a_mode = MODE_HIGH;
                        b_mode = MODE_HIGH;
                    end else begin
                        a_mode = d < 0 ? MODE_PWM : MODE_HIGH;
                        b_mode = d < 0 ? MODE_HIGH : MODE_PWM;
                        duty = 8'(255 - mag);
                    end
                end
                KIND_TB6612: begin
                    if (d == 0) begin
                        a_mode = MODE_HIGH;
                        b_mode = MODE_HIGH;
                        sl_mode = MODE_HIGH;
                    end else begin
                        a_mode = d < 0 ? MODE_LOW : MODE_HIGH;
                        b_mode = d < 0 ? MODE_HIGH : MODE_LOW;
                        sl_mode = MODE_PWM;
                        duty = 8'(mag);
                    end
                end
                default: ;
            endcase
            last_speed = 9'(s);
        endfunction

        function void note_command(logic [1:0] cmd, logic [15:0] speed);
            drive_outputs_t exp;
            logic [31:0] mult_ext;
            case (cmd)
                CMD_SET_SPEED: apply_speed(speed);
                CMD_EDGE: begin
                    if (!dir_line && count_down) begin
                        low_count--;
                        if (low_count <= -span) begin
                            low_count = 0;
                            wrap_mult = wrap_mult - 18'd1;
                        end
                    end else begin
                        low_count++;
                        if (low_count >= span) begin
                            low_count = 0;
                            wrap_mult = wrap_mult + 18'd1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    low_count = 0;
                    wrap_mult = '0;
                end
                default: ;
            endcase
            mult_ext = {{14{wrap_mult[17]}}, wrap_mult};
            exp.pad = '0;
            exp.tick = mult_ext * 32'(span) + 32'(low_count);
            exp.duty = duty;
            exp.speed_line = sl_mode;
            exp.line_b = b_mode;
            exp.line_a = a_mode;
            exp.pulse = pulse;
            held_outputs_q.push_back(exp);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        endfunction

        function void check_beat(logic [63:0] data);
            drive_outputs_t exp;
            drive_outputs_t act;
            act = data;
            if (held_outputs_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result beat 0x%0h arrived with nothing outstanding", data);
                return;
            end
            exp = held_outputs_q.pop_front();
            if (act.pulse !== exp.pulse) begin
                report("esc_pulse_us", 32'(exp.pulse), 32'(act.pulse));
            end
            if (act.line_a !== exp.line_a) begin
                report("line_a_mode", 32'(exp.line_a), 32'(act.line_a));
            end
            if (act.line_b !== exp.line_b) begin
                report("line_b_mode", 32'(exp.line_b), 32'(act.line_b));
            end
            if (act.speed_line !== exp.speed_line) begin
                report("speed_line_mode", 32'(exp.speed_line), 32'(act.speed_line));
            end
            if (act.duty !== exp.duty)             report("duty", 32'(exp.duty), 32'(act.duty));
            if (act.tick !== exp.tick)             report("tick_count", exp.tick, act.tick);
            if (act.pad !== exp.pad)               report("pad bits", 32'(exp.pad), 32'(act.pad));
        endfunction

        function int outstanding();
            return held_outputs_q.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [15:0] speed
    logic [1:0]        s_tuser;   // [1:0] cmd
    logic              m_tvalid;
    logic              m_tready;
    // [10:0] esc_pulse_us, [12:11] line_a_mode, [14:13] line_b_mode,
    // [16:15] speed_line_mode, [24:17] duty, [56:25] tick_count, [63:57] zero
    logic [63:0]       m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    wheel_state_board board;
    int  cycles;
    int  idle_chance;
    bit  tail_phase;
    bit  long_hold_req;

    wheel_drive_and_tick_counter #(.COUNT_SPAN(SPAN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request, none in the tail
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_beat(m_tdata);
            if (long_hold_req) begin
                long_hold_req = 0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !tail_phase && $urandom_range(0, 99) < idle_chance) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [15:0] speed);
        s_tvalid <= 1'b1;
        s_tdata  <= speed;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, speed);
    endtask

    task automatic maybe_gap();
        if (!tail_phase && $urandom_range(0, 99) < idle_chance) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] value, input int bits);
        logic [31:0] word;
        word = ($urandom << bits) | 32'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        board.set_reg(idx, word);
    endtask

    task automatic configure(input logic [1:0] kind, input bit rev, input bit dirl);
        drain_results();
        write_reg(REG_DRIVER_KIND, kind, 2);
        write_reg(REG_REVERSE, {1'b0, rev}, 1);
        write_reg(REG_HAS_DIR_LINE, {1'b0, dirl}, 1);
    endtask

    initial begin : stimulus
        logic [1:0] kinds [PHASES];
        logic [15:0] last_req;
        logic [15:0] spd;
        logic [1:0] cmd;
        int r;
        kinds = '{KIND_ESC, KIND_DRV8833, KIND_TB6612, KIND_ESC,
                  KIND_DRV8833, KIND_TB6612, KIND_NONE, KIND_TB6612};
        board = new(SPAN);
        idle_chance = 0;
        tail_phase = 0;
        long_hold_req = 0;
        last_req = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_SET_SPEED;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: servo esc, forward, speed sign sets count direction
        send_beat(CMD_SET_SPEED, 16'sd0);      // equal to stored zero, ignored
        send_beat(CMD_EDGE, '0);
        send_beat(CMD_SET_SPEED, 16'sh7fff);   // clamps to full forward
        send_beat(CMD_EDGE, '0);
        send_beat(CMD_SET_SPEED, 16'sd256);    // clamps to 255, not equal, applied
        send_beat(CMD_SET_SPEED, 16'sd255);    // equal to clamped value, ignored
        send_beat(CMD_SET_SPEED, 16'sh8000);   // clamps to full reverse, counts down
        send_beat(CMD_EDGE, '0);
        send_beat(CMD_EDGE, '0);
        send_beat(CMD_SET_SPEED, 16'sd0);      // zero keeps counting down
        send_beat(CMD_EDGE, '0);
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_UNUSED, 16'hffff);
        send_beat(CMD_EDGE, '0);

        configure(KIND_DRV8833, 1'b1, 1'b1);
        send_beat(CMD_SET_SPEED, -16'sd100);
        send_beat(CMD_SET_SPEED, 16'sd100);
        send_beat(CMD_SET_SPEED, 16'sd0);      // brake
        send_beat(CMD_SET_SPEED, -16'sd255);
        send_beat(CMD_EDGE, '0);

        configure(KIND_TB6612, 1'b0, 1'b0);
        send_beat(CMD_SET_SPEED, 16'sd1);
        send_beat(CMD_SET_SPEED, -16'sd1);
        send_beat(CMD_SET_SPEED, 16'sd0);      // all lines high
        send_beat(CMD_EDGE, '0);

        configure(KIND_NONE, 1'b0, 1'b0);
        send_beat(CMD_SET_SPEED, 16'sd77);     // stored, outputs unchanged
        send_beat(CMD_EDGE, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            configure(kinds[ph], ph[0], ph[1]);
            idle_chance = (ph == 3) ? 0 : $urandom_range(5, 35);
            tail_phase = (ph == PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == 50)
                    long_hold_req = 1;
                r = $urandom_range(0, 99);
                spd = 16'($urandom);
                if (r < 40)
                    cmd = CMD_SET_SPEED;
                else if (r < 88)
                    cmd = CMD_EDGE;
                else if (r < 97)
                    cmd = CMD_CLEAR;
                else
                    cmd = CMD_UNUSED;
                if (cmd == CMD_SET_SPEED) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: spd = 16'($urandom_range(0, 600) - 300);
                        4:          spd = last_req;
                        5: begin
                            case ($urandom_range(0, 4))
                                0: spd = 16'sd255;
                                1: spd = -16'sd255;
                                2: spd = 16'sd256;
                                3: spd = -16'sd256;
                                default: spd = 16'sd0;
                            endcase
                        end
                        6, 7:       spd = 16'($urandom);
                        default:    spd = 16'($urandom_range(0, 20) - 10);
                    endcase
                    last_req = spd;
                end
                maybe_gap();
                send_beat(cmd, spd);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
